@@ design/mfdu_pkg.sv @@
`default_nettype none

package mfdu_pkg;

    localparam int SLOTS_DEFAULT   = 5;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int QUEUE_DEPTH     = 2;

    localparam int SLOT_W    = 3;
    localparam int ID_W      = 11;
    localparam int MASK_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int REG_DAT_W = 11;

    localparam logic [SLOT_W-1:0] BUS1_SLOT = SLOT_W'(4);

    localparam logic [ID_W-1:0]   SLOT0_ID_RST    = ID_W'(11'h201);
    localparam logic [ID_W-1:0]   SLOT1_ID_RST    = ID_W'(11'h202);
    localparam logic [ID_W-1:0]   SLOT2_ID_RST    = ID_W'(11'h203);
    localparam logic [ID_W-1:0]   SLOT3_ID_RST    = ID_W'(11'h206);
    localparam logic [MASK_W-1:0] UNWRAP_MASK_RST = MASK_W'(17);

    localparam logic signed [17:0] HALF_TURN     = 18'(COUNTS_PER_TURN / 2);
    localparam logic signed [17:0] NEG_HALF_TURN = -HALF_TURN;
    localparam logic [31:0]        TURN_STEP     = 32'(COUNTS_PER_TURN);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SLOT0_ID    = 3'd0,
        REG_SLOT1_ID    = 3'd1,
        REG_SLOT2_ID    = 3'd2,
        REG_SLOT3_ID    = 3'd3,
        REG_UNWRAP_MASK = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic            bus;
        logic [ID_W-1:0] frame_id;
        logic [7:0]      byte0;
        logic [7:0]      byte1;
        logic [7:0]      byte2;
        logic [7:0]      byte3;
        logic [7:0]      byte4;
        logic [7:0]      byte5;
        logic [7:0]      byte6;
    } frame_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [15:0]        angle;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temperature;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [15:0]        angle;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temperature;
        logic signed [31:0] turns;
        logic signed [31:0] total_position;
    } result_t;

endpackage

`default_nettype wire

@@ design/motor_feedback_decode_unwrap_core.sv @@
// Path: an accepted request is written into the middle queue; the back stage does the
// per-slot state read-modify-write on its head and writes the result into the result queue.
// Throughput: one request per cycle unless a queue is full; both queues hold two entries.
// Reset: rst_n asynchronous active low; clears both queues, all per-slot tracking state,
// and loads the identifier and unwrap mask registers with their defaults.
`default_nettype none

module motor_feedback_decode_unwrap_core #(
    parameter int SLOTS = mfdu_pkg::SLOTS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire mfdu_pkg::frame_t               frame,
    output logic                                empty,
    input  wire logic                           pop,
    output mfdu_pkg::result_t                   result,
    input  wire logic                           wr_en,
    input  wire logic [mfdu_pkg::REG_IDX_W-1:0] wr_index,
    input  wire logic [mfdu_pkg::REG_DAT_W-1:0] wr_data
);

    import mfdu_pkg::*;

    logic              accept;
    logic              q_push, q_pop, q_empty;
    item_t             q_wdata, q_rdata;
    logic [MASK_W-1:0] unwrap_mask;
    logic              res_push, res_full;
    result_t           res_item;

    assign accept = push && !full;

    mfdu_front #(.SLOTS(SLOTS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .accept      (accept),
        .frame       (frame),
        .q_push      (q_push),
        .q_item      (q_wdata),
        .unwrap_mask (unwrap_mask)
    );

    mfdu_fifo #(.DEPTH(QUEUE_DEPTH), .T(item_t)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_wdata),
        .full  (full),
        .rd    (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    mfdu_back #(.SLOTS(SLOTS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (q_rdata),
        .q_pop       (q_pop),
        .unwrap_mask (unwrap_mask),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_item    (res_item)
    );

    mfdu_fifo #(.DEPTH(QUEUE_DEPTH), .T(result_t)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res_item),
        .full  (res_full),
        .rd    (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

@@ design/mfdu_fifo.sv @@
`default_nettype none

module mfdu_fifo #(
    parameter int  DEPTH = 2,
    parameter type T     = logic
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire T     wdata,
    output logic      full,
    input  wire logic rd,
    output T          rdata,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ design/mfdu_front.sv @@
`default_nettype none

module mfdu_front #(
    parameter int SLOTS = mfdu_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [mfdu_pkg::REG_IDX_W-1:0] wr_index,
    input  wire logic [mfdu_pkg::REG_DAT_W-1:0] wr_data,
    input  wire logic                          accept,
    input  wire mfdu_pkg::frame_t              frame,
    output logic                               q_push,
    output mfdu_pkg::item_t                    q_item,
    output logic [mfdu_pkg::MASK_W-1:0]        unwrap_mask
);

    import mfdu_pkg::*;

    logic [ID_W-1:0]   slot0_id_reg, slot1_id_reg, slot2_id_reg, slot3_id_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [SLOT_W-1:0] slot;
    logic              hit;

    assign unwrap_mask = mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_id_reg <= SLOT0_ID_RST;
            slot1_id_reg <= SLOT1_ID_RST;
            slot2_id_reg <= SLOT2_ID_RST;
            slot3_id_reg <= SLOT3_ID_RST;
            mask_reg     <= UNWRAP_MASK_RST;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_SLOT0_ID:    slot0_id_reg <= wr_data[ID_W-1:0];
                REG_SLOT1_ID:    slot1_id_reg <= wr_data[ID_W-1:0];
                REG_SLOT2_ID:    slot2_id_reg <= wr_data[ID_W-1:0];
                REG_SLOT3_ID:    slot3_id_reg <= wr_data[ID_W-1:0];
                REG_UNWRAP_MASK: mask_reg     <= wr_data[MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    // bus-1 frames take BUS1_SLOT; otherwise the lowest matching slot wins
    always_comb
    begin
        hit  = 1'b1;
        slot = '0;
        if (frame.bus)
        begin
            slot = BUS1_SLOT;
        end
        else if (frame.frame_id == slot0_id_reg)
        begin
            slot = SLOT_W'(0);
        end
        else if (frame.frame_id == slot1_id_reg)
        begin
            slot = SLOT_W'(1);
        end
        else if (frame.frame_id == slot2_id_reg)
        begin
            slot = SLOT_W'(2);
        end
        else if (frame.frame_id == slot3_id_reg)
        begin
            slot = SLOT_W'(3);
        end
        else
        begin
            hit = 1'b0;
        end
        if ({{(32 - SLOT_W){1'b0}}, slot} >= 32'(SLOTS))
        begin
            hit = 1'b0;
        end
    end

    assign q_push             = accept && hit;
    assign q_item.slot        = slot;
    assign q_item.angle       = {frame.byte0, frame.byte1};
    assign q_item.speed       = {frame.byte2, frame.byte3};
    assign q_item.current     = {frame.byte4, frame.byte5};
    assign q_item.temperature = frame.byte6;

endmodule

`default_nettype wire

@@ design/mfdu_back.sv @@
`default_nettype none

module mfdu_back #(
    parameter int SLOTS = mfdu_pkg::SLOTS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    input  wire mfdu_pkg::item_t        q_item,
    output logic                        q_pop,
    input  wire logic [mfdu_pkg::MASK_W-1:0] unwrap_mask,
    input  wire logic                   res_full,
    output logic                        res_push,
    output mfdu_pkg::result_t           res_item
);

    import mfdu_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] seen_reg;
    logic [15:0]      prev_reg   [SLOTS];
    logic [15:0]      offset_reg [SLOTS];
    logic [31:0]      turn_reg   [SLOTS];
    logic [31:0]      base_reg   [SLOTS];
    logic [31:0]      total_reg  [SLOTS];

    logic [IDX_W-1:0]  idx;
    logic              track;
    logic signed [17:0] delta;
    logic [15:0]       offset_next;
    logic [31:0]       turn_next;
    logic [31:0]       base_next;
    logic [31:0]       total_next;

    assign q_pop    = !q_empty && !res_full;
    assign res_push = q_pop;
    assign idx      = IDX_W'(q_item.slot);
    assign track    = unwrap_mask[q_item.slot];
    assign delta    = $signed({2'b00, q_item.angle}) - $signed({2'b00, prev_reg[idx]});

    always_comb
    begin
        offset_next = offset_reg[idx];
        turn_next   = turn_reg[idx];
        base_next   = base_reg[idx];
        if (!seen_reg[idx])
        begin
            offset_next = q_item.angle;
        end
        else if (delta > HALF_TURN)
        begin
            turn_next = turn_reg[idx] - 32'd1;
            base_next = base_reg[idx] - TURN_STEP;
        end
        else if (delta < NEG_HALF_TURN)
        begin
            turn_next = turn_reg[idx] + 32'd1;
            base_next = base_reg[idx] + TURN_STEP;
        end
        total_next = base_next + {16'd0, q_item.angle} - {16'd0, offset_next};
    end

    always_comb
    begin
        res_item.slot           = q_item.slot;
        res_item.angle          = q_item.angle;
        res_item.speed          = q_item.speed;
        res_item.current        = q_item.current;
        res_item.temperature    = q_item.temperature;
        res_item.turns          = track ? turn_next : turn_reg[idx];
        res_item.total_position = track ? total_next : total_reg[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                prev_reg[i]   <= '0;
                offset_reg[i] <= '0;
                turn_reg[i]   <= '0;
                base_reg[i]   <= '0;
                total_reg[i]  <= '0;
            end
        end
        else if (q_pop && track)
        begin
            seen_reg[idx]   <= 1'b1;
            prev_reg[idx]   <= q_item.angle;
            offset_reg[idx] <= offset_next;
            turn_reg[idx]   <= turn_next;
            base_reg[idx]   <= base_next;
            total_reg[idx]  <= total_next;
        end
    end

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> ({{(32 - SLOT_W){1'b0}}, q_item.slot} < 32'(SLOTS)))
        else $error("request with slot beyond storage");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg & $past(seen_reg)) == $past(seen_reg))
        else $error("first-frame flag cleared");

    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !res_full && !q_empty)
        else $error("request moved without result room");

    a_untracked_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !track) |=> $stable(seen_reg))
        else $error("tracking state changed for disabled slot");

endmodule

`default_nettype wire
